FILE: sv/lutip_pkg.sv
package lutip_pkg;

  // Input item: breakpoint write or interpolation query.
  typedef struct packed {
    logic               kind;
    logic [5:0]         point_index;
    logic signed [15:0] point_x;
    logic signed [15:0] point_y;
    logic signed [15:0] query_x;
  } in_t;

  // Result item of a query.
  typedef struct packed {
    logic signed [15:0] mapped_value;
    logic               zero_span;
  } out_t;

  // Item kinds.
  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  // Configuration register indexes and write data width.
  localparam int unsigned CFG_DATA_W      = 7;
  localparam logic        REG_POINT_COUNT = 1'b0;
  localparam logic        REG_LUT_MODE    = 1'b1;

  // Fewest breakpoints that form a segment.
  localparam int unsigned MIN_COUNT = 2;

  // Edge handling modes.
  typedef enum logic [1:0] {
    MODE_EXTRAP     = 2'd0,
    MODE_EXTRAP_POS = 2'd1,
    MODE_LIMIT      = 2'd2,
    MODE_CALIB      = 2'd3
  } lut_mode_e;

  // Divider operand widths: product magnitude and segment span magnitude.
  localparam int unsigned DVD_W = 32;
  localparam int unsigned DVS_W = 16;

  // Query sequencer states.
  typedef enum logic [3:0] {
    S_IDLE,
    S_LAST,
    S_FIRST,
    S_TOP,
    S_SCAN,
    S_MUL,
    S_DIVST,
    S_DIV,
    S_FIN
  } state_e;

endpackage

FILE: sv/lutip_div.sv
module lutip_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [lutip_pkg::DVD_W-1:0]   dividend_i,
  input  logic [lutip_pkg::DVS_W-1:0]   divisor_i,
  output logic                          done_o,
  output logic [lutip_pkg::DVD_W-1:0]   quotient_o
);

  localparam int unsigned CNT_W = $clog2(lutip_pkg::DVD_W);

  logic                        busy_q, busy_d;
  logic                        done_q, done_d;
  logic [CNT_W-1:0]            cnt_q, cnt_d;
  logic [lutip_pkg::DVS_W-1:0] rem_q, rem_d;
  logic [lutip_pkg::DVS_W-1:0] dvs_q, dvs_d;
  logic [lutip_pkg::DVD_W-1:0] quo_q, quo_d;
  logic [lutip_pkg::DVS_W:0]   shifted;
  logic [lutip_pkg::DVS_W:0]   diff;
  logic                        ge;

  // One restoring step: bring down the next dividend bit and try a subtract.
  always_comb begin
    shifted = {rem_q, quo_q[lutip_pkg::DVD_W-1]};
    diff    = shifted - {1'b0, dvs_q};
    ge      = shifted >= {1'b0, dvs_q};
  end

  // Step control and datapath.
  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    quo_d  = quo_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      dvs_d  = divisor_i;
      quo_d  = dividend_i;
    end else if (busy_q) begin
      rem_d = ge ? diff[lutip_pkg::DVS_W-1:0] : shifted[lutip_pkg::DVS_W-1:0];
      quo_d = {quo_q[lutip_pkg::DVD_W-2:0], ge};
      cnt_d = cnt_q + CNT_W'(1);
      if (cnt_q == CNT_W'(lutip_pkg::DVD_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // Operand and partial result registers.
  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dvs_q <= dvs_d;
    quo_q <= quo_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

FILE: sv/lut_interp_1d_modes_unit.sv
// Piecewise-linear 1-D lookup table. Write items store one (x, y) breakpoint
// in a breakpoint memory with one write and one read port and give no result.
// A query item gives one result: the table value at query_x, saturated to 16
// bits and adjusted by lut_mode. A query reads the last and first breakpoints,
// then either the next-to-last one (query above the table) or walks the memory
// one entry per cycle until the segment is found, multiplies once and runs a
// bit-serial divide. The breakpoint search and the divider set the time a
// query takes, and direct results (too few points, limit clamps, calibration
// offset, zero-width segment) skip the divider. A finished result waits in an
// output register, so write items are taken while it waits. Breakpoints must
// be written before a query reads them.
module lut_interp_1d_modes_unit #(
  parameter int unsigned MAX_POINTS = 64
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  lutip_pkg::in_t                      in_data_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output lutip_pkg::out_t                     out_data_o,
  input  logic                                cfg_we_i,
  input  logic                                cfg_index_i,
  input  logic [lutip_pkg::CFG_DATA_W-1:0]    cfg_wdata_i
);

  localparam int unsigned AW = $clog2(MAX_POINTS);

  // Configuration registers.
  logic [6:0]           point_count_q;
  lutip_pkg::lut_mode_e lut_mode_q;

  // Breakpoint memory: {x, y} per entry, one write and one registered read.
  logic [31:0]   mem_q [MAX_POINTS];
  logic [31:0]   rdata_q;
  logic [AW-1:0] raddr;
  logic [AW-1:0] waddr;
  logic          mem_we;

  // Sequencer and datapath registers.
  lutip_pkg::state_e  state_q, state_d;
  logic signed [15:0] q_q, q_d;
  logic [AW-1:0]      nm1_q, nm1_d;
  logic [AW-1:0]      idx_q, idx_d;
  logic signed [15:0] last_x_q, last_x_d, last_y_q, last_y_d;
  logic signed [15:0] first_x_q, first_x_d, first_y_q, first_y_d;
  logic signed [15:0] prev_x_q, prev_x_d, prev_y_q, prev_y_d;
  logic signed [15:0] ay_q, ay_d;
  logic signed [16:0] dx_q, dx_d, span_q, span_d, dy_q, dy_d;
  logic signed [33:0] prod_q, prod_d;
  logic signed [34:0] res_q, res_d;
  logic               zspan_q, zspan_d;
  logic               out_valid_q, out_valid_d;
  lutip_pkg::out_t    out_q, out_d;

  // Decision signals.
  logic               in_fire, is_query, out_free;
  logic [31:0]        cnt_ext, n_eff, widx;
  logic               n_ok, widx_ok;
  logic signed [15:0] rd_x, rd_y;
  logic               above, scan_hit, below, seg_state, direct, span_zero;
  logic signed [15:0] lo_x, lo_y, hi_x, hi_y, ax, ay;
  logic signed [34:0] direct_res;
  logic signed [15:0] sat_val, fin_val;

  // Divider link.
  logic                          div_start, div_done, q_neg;
  logic [33:0]                   prod_mag;
  logic [16:0]                   span_mag;
  logic [lutip_pkg::DVD_W-1:0]   div_quo;
  logic signed [34:0]            quo_signed;

  assign in_ready_o  = (state_q == lutip_pkg::S_IDLE);
  assign in_fire     = in_valid_i && in_ready_o;
  assign is_query    = (in_data_i.kind == lutip_pkg::KIND_QUERY);
  assign out_free    = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Configuration writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      point_count_q <= '0;
      lut_mode_q    <= lutip_pkg::MODE_EXTRAP;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        lutip_pkg::REG_POINT_COUNT: point_count_q <= cfg_wdata_i[6:0];
        lutip_pkg::REG_LUT_MODE:    lut_mode_q <= lutip_pkg::lut_mode_e'(cfg_wdata_i[1:0]);
        default: ;
      endcase
    end
  end

  // Points in use, limited to the memory depth, and the write address check.
  always_comb begin
    cnt_ext = 32'(point_count_q);
    n_eff   = (cnt_ext > 32'(MAX_POINTS)) ? 32'(MAX_POINTS) : cnt_ext;
    n_ok    = n_eff >= 32'(lutip_pkg::MIN_COUNT);
    widx    = 32'(in_data_i.point_index);
    widx_ok = widx < 32'(MAX_POINTS);
    waddr   = widx[AW-1:0];
    mem_we  = in_fire && !is_query && widx_ok;
  end

  // Breakpoint memory.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[waddr] <= {in_data_i.point_x, in_data_i.point_y};
    end
    rdata_q <= mem_q[raddr];
  end

  assign rd_x = signed'(rdata_q[31:16]);
  assign rd_y = signed'(rdata_q[15:0]);

  // Read address: last point, first point, then next-to-last or the search walk.
  always_comb begin
    case (state_q)
      lutip_pkg::S_IDLE:  raddr = n_eff[AW-1:0] - AW'(1);
      lutip_pkg::S_LAST:  raddr = '0;
      lutip_pkg::S_FIRST: raddr = (q_q > last_x_q) ? (nm1_q - AW'(1)) : AW'(1);
      lutip_pkg::S_SCAN:  raddr = idx_q + AW'(1);
      default:            raddr = '0;
    endcase
  end

  // Segment choice and direct results.
  always_comb begin
    above     = q_q > last_x_q;
    scan_hit  = q_q <= rd_x;
    below     = q_q < first_x_q;
    seg_state = (state_q == lutip_pkg::S_TOP);
    if (seg_state) begin
      lo_x = rd_x;
      lo_y = rd_y;
      hi_x = last_x_q;
      hi_y = last_y_q;
      ax   = last_x_q;
      ay   = last_y_q;
    end else begin
      lo_x = prev_x_q;
      lo_y = prev_y_q;
      hi_x = rd_x;
      hi_y = rd_y;
      ax   = below ? first_x_q : rd_x;
      ay   = below ? first_y_q : rd_y;
    end
    direct     = 1'b0;
    direct_res = '0;
    if (seg_state && lut_mode_q == lutip_pkg::MODE_CALIB) begin
      direct     = 1'b1;
      direct_res = 35'(q_q) - (35'(lo_x) - 35'(lo_y));
    end else if (lut_mode_q == lutip_pkg::MODE_LIMIT && below) begin
      direct     = 1'b1;
      direct_res = 35'(first_y_q);
    end else if (lut_mode_q == lutip_pkg::MODE_LIMIT && seg_state) begin
      direct     = 1'b1;
      direct_res = 35'(last_y_q);
    end
    span_zero = (span_q == '0);
  end

  // Divider operands: magnitudes in, sign applied afterwards.
  always_comb begin
    prod_mag   = prod_q[33] ? 34'(-prod_q) : 34'(prod_q);
    span_mag   = span_q[16] ? 17'(-span_q) : 17'(span_q);
    q_neg      = prod_q[33] ^ span_q[16];
    quo_signed = q_neg ? -35'(div_quo) : 35'(div_quo);
    div_start  = (state_q == lutip_pkg::S_DIVST);
  end

  lutip_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (prod_mag[lutip_pkg::DVD_W-1:0]),
    .divisor_i  (span_mag[lutip_pkg::DVS_W-1:0]),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  // Saturation and the nonnegative modes.
  always_comb begin
    if (res_q > 35'sd32767) begin
      sat_val = 16'sh7FFF;
    end else if (res_q < -35'sd32768) begin
      sat_val = 16'sh8000;
    end else begin
      sat_val = res_q[15:0];
    end
    if ((lut_mode_q == lutip_pkg::MODE_EXTRAP_POS || lut_mode_q == lutip_pkg::MODE_CALIB)
        && sat_val[15]) begin
      fin_val = '0;
    end else begin
      fin_val = sat_val;
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      lutip_pkg::S_IDLE: begin
        if (in_fire && is_query) begin
          state_d = n_ok ? lutip_pkg::S_LAST : lutip_pkg::S_FIN;
        end
      end
      lutip_pkg::S_LAST:  state_d = lutip_pkg::S_FIRST;
      lutip_pkg::S_FIRST: state_d = above ? lutip_pkg::S_TOP : lutip_pkg::S_SCAN;
      lutip_pkg::S_TOP:   state_d = direct ? lutip_pkg::S_FIN : lutip_pkg::S_MUL;
      lutip_pkg::S_SCAN: begin
        if (scan_hit) begin
          state_d = direct ? lutip_pkg::S_FIN : lutip_pkg::S_MUL;
        end
      end
      lutip_pkg::S_MUL:   state_d = span_zero ? lutip_pkg::S_FIN : lutip_pkg::S_DIVST;
      lutip_pkg::S_DIVST: state_d = lutip_pkg::S_DIV;
      lutip_pkg::S_DIV: begin
        if (div_done) begin
          state_d = lutip_pkg::S_FIN;
        end
      end
      lutip_pkg::S_FIN: begin
        if (out_free) begin
          state_d = lutip_pkg::S_IDLE;
        end
      end
      default: state_d = lutip_pkg::S_IDLE;
    endcase
  end

  // Datapath updates per state.
  always_comb begin
    q_d         = q_q;
    nm1_d       = nm1_q;
    idx_d       = idx_q;
    last_x_d    = last_x_q;
    last_y_d    = last_y_q;
    first_x_d   = first_x_q;
    first_y_d   = first_y_q;
    prev_x_d    = prev_x_q;
    prev_y_d    = prev_y_q;
    ay_d        = ay_q;
    dx_d        = dx_q;
    span_d      = span_q;
    dy_d        = dy_q;
    prod_d      = prod_q;
    res_d       = res_q;
    zspan_d     = zspan_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_ready_i;
    case (state_q)
      lutip_pkg::S_IDLE: begin
        if (in_fire && is_query) begin
          q_d     = in_data_i.query_x;
          nm1_d   = n_eff[AW-1:0] - AW'(1);
          res_d   = '0;
          zspan_d = 1'b0;
        end
      end
      lutip_pkg::S_LAST: begin
        last_x_d = rd_x;
        last_y_d = rd_y;
      end
      lutip_pkg::S_FIRST: begin
        first_x_d = rd_x;
        first_y_d = rd_y;
        prev_x_d  = rd_x;
        prev_y_d  = rd_y;
        idx_d     = AW'(1);
      end
      lutip_pkg::S_TOP, lutip_pkg::S_SCAN: begin
        if (seg_state || scan_hit) begin
          if (direct) begin
            res_d = direct_res;
          end else begin
            ay_d   = ay;
            dx_d   = 17'(ax) - 17'(q_q);
            span_d = 17'(hi_x) - 17'(lo_x);
            dy_d   = 17'(hi_y) - 17'(lo_y);
          end
        end else begin
          prev_x_d = rd_x;
          prev_y_d = rd_y;
          idx_d    = idx_q + AW'(1);
        end
      end
      lutip_pkg::S_MUL: begin
        if (span_zero) begin
          res_d   = 35'(ay_q);
          zspan_d = 1'b1;
        end else begin
          prod_d = dy_q * dx_q;
        end
      end
      lutip_pkg::S_DIV: begin
        if (div_done) begin
          res_d = 35'(ay_q) - quo_signed;
        end
      end
      lutip_pkg::S_FIN: begin
        if (out_free) begin
          out_d.mapped_value = fin_val;
          out_d.zero_span    = zspan_q;
          out_valid_d        = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= lutip_pkg::S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    q_q       <= q_d;
    nm1_q     <= nm1_d;
    idx_q     <= idx_d;
    last_x_q  <= last_x_d;
    last_y_q  <= last_y_d;
    first_x_q <= first_x_d;
    first_y_q <= first_y_d;
    prev_x_q  <= prev_x_d;
    prev_y_q  <= prev_y_d;
    ay_q      <= ay_d;
    dx_q      <= dx_d;
    span_q    <= span_d;
    dy_q      <= dy_d;
    prod_q    <= prod_d;
    res_q     <= res_d;
    zspan_q   <= zspan_d;
    out_q     <= out_d;
  end

endmodule

FILE: tb/sv/lut_interp_checker.sv
// Watches the item, result and register ports of the lookup table unit.
// It keeps its own copy of the breakpoints and registers and queues the
// mapped value for every query transfer. Each result transfer is compared
// against the oldest queued value.
module lut_interp_checker
  import lutip_pkg::*;
#(
  parameter int unsigned MAX_POINTS = 64
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  logic                  in_ready_i,
  input  in_t                   in_data_i,
  input  logic                  out_valid_i,
  input  logic                  out_ready_i,
  input  out_t                  out_data_i,
  input  logic                  cfg_we_i,
  input  logic                  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  output int                    mismatch_count_o,
  output int                    pending_o
);

  // Shadow copy of the breakpoint memory and the registers.
  logic signed [15:0] bp_x [MAX_POINTS];
  logic signed [15:0] bp_y [MAX_POINTS];
  logic [6:0]         cur_count;
  lut_mode_e          cur_mode;

  // Mapped values still owed by the block, oldest first.
  out_t mapped_q[$];
  int   mismatches;
  int   pending_cnt;

  assign mismatch_count_o = mismatches;
  assign pending_o        = pending_cnt;

  // One printed line per mismatch, and the count goes up.
  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t: %s", $time, msg);
    mismatches++;
  endtask

  // Interpolates query_x through the shadow table under the current mode.
  function automatic out_t map_through_table(input logic signed [15:0] query_x);
    out_t   r;
    int     n;
    int     k;
    int     i;
    longint q;
    longint ax;
    longint ay;
    longint dx;
    longint span;
    longint res;
    bit     flag;
    bit     done;
    bit     found;
    n     = (cur_count > MAX_POINTS) ? MAX_POINTS : int'(cur_count);
    q     = query_x;
    res   = 0;
    flag  = 1'b0;
    done  = 1'b0;
    found = 1'b0;
    if (n >= MIN_COUNT) begin
      // Pick the segment and its anchor point.
      ax = bp_x[n-1];
      ay = bp_y[n-1];
      k  = n - 2;
      if (q > longint'(bp_x[n-1])) begin
        if (cur_mode == MODE_CALIB) begin
          res  = q - (longint'(bp_x[k]) - longint'(bp_y[k]));
          done = 1'b1;
        end
      end else begin
        for (i = 1; i < n; i++) begin
          if (!found && q <= longint'(bp_x[i])) begin
            k     = i - 1;
            ax    = bp_x[i];
            ay    = bp_y[i];
            found = 1'b1;
          end
        end
        if (q < longint'(bp_x[0])) begin
          ax = bp_x[0];
          ay = bp_y[0];
        end
      end

      // Limit mode clamps to the end values outside the table.
      if (!done && cur_mode == MODE_LIMIT) begin
        if (q < longint'(bp_x[0])) begin
          res  = bp_y[0];
          done = 1'b1;
        end else if (q > longint'(bp_x[n-1])) begin
          res  = bp_y[n-1];
          done = 1'b1;
        end
      end

      // Linear interpolation from the anchor, or the anchor on a zero-width segment.
      if (!done) begin
        dx   = ax - q;
        span = longint'(bp_x[k+1]) - longint'(bp_x[k]);
        if (span == 0) begin
          flag = 1'b1;
          res  = ay;
        end else begin
          res = ay - ((longint'(bp_y[k+1]) - longint'(bp_y[k])) * dx) / span;
        end
      end

      if (res > 32767) res = 32767;
      if (res < -32768) res = -32768;
      if ((cur_mode == MODE_EXTRAP_POS || cur_mode == MODE_CALIB) && res < 0) res = 0;
    end
    r.mapped_value = res[15:0];
    r.zero_span    = flag;
    return r;
  endfunction

  // Sample all three ports at each rising edge.
  always @(posedge clk_i or negedge rst_ni) begin : monitor
    out_t want;
    if (!rst_ni) begin
      for (int i = 0; i < MAX_POINTS; i++) begin
        bp_x[i] = '0;
        bp_y[i] = '0;
      end
      cur_count   = '0;
      cur_mode    = MODE_EXTRAP;
      mapped_q.delete();
      mismatches  = 0;
      pending_cnt = 0;
    end else begin
      // Register writes.
      if (cfg_we_i) begin
        if (cfg_index_i == REG_POINT_COUNT) begin
          cur_count = cfg_wdata_i[6:0];
        end else begin
          cur_mode = lut_mode_e'(cfg_wdata_i[1:0]);
        end
      end

      // Result transfers are checked against the oldest expectation.
      if (out_valid_i && out_ready_i) begin
        if (mapped_q.size() == 0) begin
          report_mismatch($sformatf("unexpected result value %0d zero_span %0b",
                                    out_data_i.mapped_value, out_data_i.zero_span));
        end else begin
          want = mapped_q.pop_front();
          if (out_data_i.mapped_value !== want.mapped_value) begin
            report_mismatch($sformatf("mapped_value got %0d want %0d",
                                      out_data_i.mapped_value, want.mapped_value));
          end
          if (out_data_i.zero_span !== want.zero_span) begin
            report_mismatch($sformatf("zero_span got %0b want %0b",
                                      out_data_i.zero_span, want.zero_span));
          end
        end
      end

      // Item transfers update the table or queue a prediction.
      if (in_valid_i && in_ready_i) begin
        if (in_data_i.kind == KIND_WRITE) begin
          if (in_data_i.point_index < MAX_POINTS) begin
            bp_x[in_data_i.point_index] = in_data_i.point_x;
            bp_y[in_data_i.point_index] = in_data_i.point_y;
          end
        end else begin
          mapped_q.push_back(map_through_table(in_data_i.query_x));
        end
      end
      pending_cnt = mapped_q.size();
    end
  end

endmodule

FILE: tb/sv/tb_lut_interp_1d_modes_unit.sv
// Stimulus and verdict for the lookup table unit; the checker does the rest.
module tb_lut_interp_1d_modes_unit;
  import lutip_pkg::*;

  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  in_valid    = 1'b0;
  logic                  in_ready;
  in_t                   in_data     = '0;
  logic                  out_valid;
  logic                  out_ready   = 1'b0;
  out_t                  out_data;
  logic                  cfg_we      = 1'b0;
  logic                  cfg_index   = 1'b0;
  logic [CFG_DATA_W-1:0] cfg_wdata   = '0;
  int                    mismatch_count;
  int                    pending;

  // Per-phase ceilings for the random gaps of each side.
  int src_max  = 13;
  int sink_max = 13;
  // Items handed over, used only to stop the random part.
  int sent = 0;
  // Breakpoint x values as last written, used to aim queries.
  logic signed [15:0] tbl_x [64];

  lut_interp_1d_modes_unit u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_wdata_i (cfg_wdata)
  );

  lut_interp_checker u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid),
    .in_ready_i       (in_ready),
    .in_data_i        (in_data),
    .out_valid_i      (out_valid),
    .out_ready_i      (out_ready),
    .out_data_i       (out_data),
    .cfg_we_i         (cfg_we),
    .cfg_index_i      (cfg_index),
    .cfg_wdata_i      (cfg_wdata),
    .mismatch_count_o (mismatch_count),
    .pending_o        (pending)
  );

  // Clock.
  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // Run limit, far above the slowest correct run.
  initial begin
    #(64'd8_000_000);
    $display("lut_interp_1d_modes_unit regression: fail");
    $finish;
  end

  function automatic logic signed [15:0] clamp16(input int v);
    if (v > 32767) return 16'sh7FFF;
    if (v < -32768) return 16'sh8000;
    return v[15:0];
  endfunction

  // Offers one item after a random gap and returns at its transfer edge.
  task automatic send_item(input in_t item);
    int gap;
    gap = $urandom_range(0, src_max);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk_i); while (!in_ready);
    sent++;
  endtask

  task automatic send_write(input int idx, input int x, input int y);
    in_t item;
    item.kind        = KIND_WRITE;
    item.point_index = idx[5:0];
    item.point_x     = x[15:0];
    item.point_y     = y[15:0];
    item.query_x     = 16'($urandom);
    tbl_x[idx[5:0]]  = x[15:0];
    send_item(item);
  endtask

  task automatic send_query(input int q);
    in_t item;
    item.kind        = KIND_QUERY;
    item.point_index = 6'($urandom);
    item.point_x     = 16'($urandom);
    item.point_y     = 16'($urandom);
    item.query_x     = q[15:0];
    send_item(item);
  endtask

  // Writes both registers on back-to-back edges while the block is idle.
  task automatic write_regs(input int count, input lut_mode_e mode);
    cfg_we    <= 1'b1;
    cfg_index <= REG_POINT_COUNT;
    cfg_wdata <= count[6:0];
    @(posedge clk_i);
    cfg_index <= REG_LUT_MODE;
    cfg_wdata <= CFG_DATA_W'(mode);
    @(posedge clk_i);
    cfg_we    <= 1'b0;
  endtask

  // Stops offering, waits for every owed result, then lets a write settle.
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (128) @(posedge clk_i);
  endtask

  // Result side: random back-pressure plus two long hold-offs.
  initial begin : sink
    int gap;
    int taken;
    taken = 0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (taken == 120 || taken == 500) begin
        out_ready <= 1'b0;
        repeat (1500) @(posedge clk_i);
      end else begin
        gap = $urandom_range(0, sink_max);
        if (gap > 0) begin
          out_ready <= 1'b0;
          repeat (gap) @(posedge clk_i);
        end
      end
      out_ready <= 1'b1;
      do @(posedge clk_i); while (!out_valid);
      taken++;
    end
  end

  // Item side: directed cases, then random phases, then the verdict.
  initial begin : source
    int n;
    int nw;
    int nq;
    int shape;
    int step_max;
    int acc;
    int m;
    int lo;
    int hi;
    int qv;
    int sel;
    lut_mode_e md;

    for (int i = 0; i < 64; i++) tbl_x[i] = '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // With no points or one point every query maps to zero.
    write_regs(0, MODE_EXTRAP);
    send_query(-32768);
    send_query(32767);
    drain();
    write_regs(1, MODE_EXTRAP_POS);
    send_write(0, -32768, 32767);
    send_query(0);
    drain();

    // A four-point table whose top segment has zero width, plus the last index.
    write_regs(4, MODE_EXTRAP);
    send_write(1, -1000, -32768);
    send_write(2, 1000, 32767);
    send_write(3, 1000, 0);
    send_write(63, 32767, -32768);
    send_query(-32768);
    send_query(-1000);
    send_query(0);
    send_query(32767);
    drain();

    // Same table under the other three modes, below, inside and above.
    for (int mi = 1; mi < 4; mi++) begin
      write_regs(4, lut_mode_e'(mi[1:0]));
      send_query(-32768);
      send_query(500);
      send_query(32767);
      drain();
    end

    // Random phases: new registers, a fresh table, then queries with some noise.
    sent = 0;
    while (sent < 1500) begin
      sel = $urandom_range(0, 19);
      if (sel == 0) n = $urandom_range(0, 1);
      else if (sel == 1) n = 64;
      else if (sel == 2) n = 2;
      else if (sel < 5) n = $urandom_range(13, 63);
      else n = $urandom_range(3, 12);
      md = lut_mode_e'(2'($urandom_range(0, 3)));
      case ($urandom_range(0, 3))
        0: src_max = 0;
        1: src_max = 13;
        2: src_max = 3;
        default: src_max = $urandom_range(0, 13);
      endcase
      case ($urandom_range(0, 3))
        0: sink_max = 0;
        1: sink_max = 13;
        2: sink_max = 3;
        default: sink_max = $urandom_range(0, 13);
      endcase
      write_regs(n, md);

      // Table shapes: ascending, ascending with repeats, unordered, or tightly packed.
      shape    = $urandom_range(0, 9);
      nw       = (n < 2) ? 2 : n;
      step_max = (shape == 8) ? 40 : 65000 / nw;
      acc      = -32768 + int'($urandom_range(0, (shape == 8) ? 60000 : 500));
      for (int i = 0; i < nw; i++) begin
        if (i > 0) begin
          if (shape == 6 && $urandom_range(0, 3) == 0) acc = acc + 0;
          else acc = acc + int'($urandom_range(1, step_max));
        end
        if (shape == 7) send_write(i, int'($urandom), int'($urandom));
        else send_write(i, acc, int'($urandom));
      end

      // Queries aimed at breakpoints, inside, outside and at the field extremes.
      nq = nw;
      m  = $urandom_range(8, 40);
      for (int j = 0; j < m; j++) begin
        if ($urandom_range(0, 9) == 0) begin
          send_write($urandom_range(0, 63), int'($urandom), int'($urandom));
        end else begin
          lo = tbl_x[0];
          hi = tbl_x[nq-1];
          if (lo > hi) begin
            acc = lo;
            lo  = hi;
            hi  = acc;
          end
          case ($urandom_range(0, 8))
            0, 1: begin
              qv = tbl_x[$urandom_range(0, nq - 1)];
              qv = qv + int'($urandom_range(0, 2)) - 1;
            end
            2, 3, 4: qv = lo + int'($urandom_range(0, hi - lo));
            5: qv = int'($urandom_range(0, 65535)) - 32768;
            6: qv = lo - int'($urandom_range(1, 3000));
            7: qv = hi + int'($urandom_range(1, 3000));
            default: qv = ($urandom_range(0, 1) == 0) ? -32768 : 32767;
          endcase
          send_query(clamp16(qv));
        end
      end
      drain();
    end

    if (mismatch_count == 0) begin
      $display("lut_interp_1d_modes_unit regression: pass");
    end else begin
      $display("lut_interp_1d_modes_unit regression: fail");
    end
    $finish;
  end

endmodule

FILE: sim.f
sv/lutip_pkg.sv
sv/lutip_div.sv
sv/lut_interp_1d_modes_unit.sv
tb/sv/lut_interp_checker.sv
tb/sv/tb_lut_interp_1d_modes_unit.sv
